FILE: hw/rtl/cfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants of the character frame buffer
// Cell store geometry, item codes, the command that travels from front to
// back, and the back-end state encoding.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 32;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

  localparam int SYM_W       = 16;
  localparam int POS_W       = 16;
  localparam int WIDTH_REG_W = 7;
  localparam int HEIGHT_REG_W = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [SYM_W-1:0] SPACE_CODE = SYM_W'(16'h0020);

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(64);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(32);
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = WIDTH_REG_W'(MAX_COLUMNS);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = HEIGHT_REG_W'(MAX_ROWS);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DUMP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CLEAR,
    CMD_DUMP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;      // cell address, or row base for a dump
    logic [SYM_W-1:0]   data;
    logic [COL_W-1:0]   last_col;  // last column of a dump
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CLEAR,
    B_DUMP
  } back_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cfc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_front: item decode, text cursor and clipping
// Holds the size registers and the cursor, clips draws against the area in
// use and turns each accepted item into at most one back-end command.
// ----------------------------------------------------------------------------
module cfc_front import cfc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [1:0]            opcode,
  input  wire logic                  start_run,
  input  wire logic [POS_W-1:0]      pos_x,
  input  wire logic [POS_W-1:0]      pos_y,
  input  wire logic [1:0]            direction,
  input  wire logic [SYM_W-1:0]      symbol,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       push,
  output cmd_t                       cmd
);

  logic [WIDTH_REG_W-1:0]  width_cells;
  logic [HEIGHT_REG_W-1:0] height_cells;
  logic [POS_W-1:0]        cursor_x, cursor_x_next;
  logic [POS_W-1:0]        cursor_y, cursor_y_next;
  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [POS_W-1:0]        cur_x, cur_y;
  logic                    in_area;
  logic                    row_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cells  <= WIDTH_RESET;
      height_cells <= HEIGHT_RESET;
      cursor_x     <= '0;
      cursor_y     <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_WIDTH) begin
        width_cells <= cfg_data[WIDTH_REG_W-1:0];
      end
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        height_cells <= cfg_data[HEIGHT_REG_W-1:0];
      end
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  // out-of-range sizes saturate to 1..max
  always_comb begin
    if (width_cells == '0) begin
      eff_w = WIDTH_REG_W'(1);
    end else if (width_cells > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = width_cells;
    end
    if (height_cells == '0) begin
      eff_h = HEIGHT_REG_W'(1);
    end else if (height_cells > HEIGHT_MAX) begin
      eff_h = HEIGHT_MAX;
    end else begin
      eff_h = height_cells;
    end
  end

  assign cur_x   = start_run ? pos_x : cursor_x;
  assign cur_y   = start_run ? pos_y : cursor_y;
  assign in_area = (cur_x < POS_W'(eff_w)) && (cur_y < POS_W'(eff_h));
  assign row_ok  = pos_y < POS_W'(eff_h);

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    push          = 1'b0;
    cmd.kind      = CMD_WRITE;
    cmd.addr      = {cur_y[ROW_W-1:0], cur_x[COL_W-1:0]};
    cmd.data      = symbol;
    cmd.last_col  = COL_W'(eff_w - WIDTH_REG_W'(1));
    if (accept) begin
      case (opcode_t'(opcode))
        OP_DRAW: begin
          push          = in_area;
          cursor_x_next = cur_x;
          cursor_y_next = cur_y;
          case (dir_t'(direction))
            DIR_UP:    cursor_y_next = cur_y - POS_W'(1);
            DIR_DOWN:  cursor_y_next = cur_y + POS_W'(1);
            DIR_LEFT:  cursor_x_next = cur_x - POS_W'(1);
            DIR_RIGHT: cursor_x_next = cur_x + POS_W'(1);
            default:   cursor_x_next = cur_x + POS_W'(1);
          endcase
        end
        OP_CLEAR: begin
          push     = 1'b1;
          cmd.kind = CMD_CLEAR;
        end
        OP_DUMP: begin
          push     = row_ok;
          cmd.kind = CMD_DUMP;
          cmd.addr = {pos_y[ROW_W-1:0], COL_W'(0)};
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_queue: command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cfc_queue import cfc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head,
  output logic      full
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign valid  = count != '0;
  assign full   = count == QCNT_W'(QUEUE_DEPTH);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_back: cell store and command execution
// Writes cells, sweeps the store with spaces (after reset and on clear) and
// reads out a row one cell per cycle.
// ----------------------------------------------------------------------------
module cfc_back import cfc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  cmd_t               cmd,
  output logic               pop,
  output back_status_t       status,
  output logic               result_valid,
  output logic [SYM_W-1:0]   cell_symbol,
  output logic               is_last
);

  back_state_t        state, state_next;
  logic [ADDR_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0]  base, base_next;
  logic [COL_W-1:0]   last_col, last_col_next;
  logic               init_done, init_done_next;
  logic               rd_valid, rd_valid_next;
  logic               rd_last, rd_last_next;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [SYM_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;

  cfc_ram #(
    .WIDTH(SYM_W),
    .DEPTH(CELL_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(cell_symbol)
  );

  // reset starts a full sweep with spaces
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      cnt       <= '0;
      init_done <= 1'b0;
      rd_valid  <= 1'b0;
      rd_last   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      init_done <= init_done_next;
      rd_valid  <= rd_valid_next;
      rd_last   <= rd_last_next;
    end
  end

  always_ff @(posedge clk) begin
    base     <= base_next;
    last_col <= last_col_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    base_next      = base;
    last_col_next  = last_col;
    init_done_next = init_done;
    rd_valid_next  = 1'b0;
    rd_last_next   = 1'b0;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cmd.addr;
    ram_wdata      = cmd.data;
    ram_raddr      = base + ADDR_W'(cnt[COL_W-1:0]);
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.kind)
            CMD_WRITE: begin
              ram_we = 1'b1;
            end
            CMD_CLEAR: begin
              state_next = B_CLEAR;
              cnt_next   = '0;
            end
            CMD_DUMP: begin
              state_next    = B_DUMP;
              cnt_next      = '0;
              base_next     = cmd.addr;
              last_col_next = cmd.last_col;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = SPACE_CODE;
        cnt_next  = cnt + ADDR_W'(1);
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          state_next     = B_IDLE;
          init_done_next = 1'b1;
        end
      end
      B_DUMP: begin
        rd_valid_next = 1'b1;
        rd_last_next  = cnt[COL_W-1:0] == last_col;
        cnt_next      = cnt + ADDR_W'(1);
        if (cnt[COL_W-1:0] == last_col) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  assign status.init_busy = !init_done;
  assign result_valid     = rd_valid;
  assign is_last          = rd_last;

endmodule
`default_nettype wire

FILE: hw/rtl/char_framebuffer_clipped_text_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_framebuffer_clipped_text_core: character frame buffer, clipped text
// 64 x 32 cells of 16-bit codes. Draw items write at a stepping text cursor,
// clipped to the configured area; clear fills with spaces; dump reads a row.
// ----------------------------------------------------------------------------
//  channel  signals                                        handshake
//  item     start, busy, opcode, start_run, pos_x, pos_y,  taken on start & !busy
//           direction, symbol
//  result   result_valid, cell_symbol, is_last             one-cycle strobe
//  config   cfg_we, cfg_index, cfg_data                    taken on cfg_we
//
// The back end retires one write per cycle while it is not clearing or dumping.
// A clear holds the store port while it sweeps every cell; a dump gives width
// cells on consecutive cycles from the registered store read in its dump state.
// After reset the store is swept with spaces while busy is high.
// busy rises when the 4-entry command queue is full; results are never held.
module char_framebuffer_clipped_text_core import cfc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            opcode,
  input  wire logic                  start_run,
  input  wire logic [POS_W-1:0]      pos_x,
  input  wire logic [POS_W-1:0]      pos_y,
  input  wire logic [1:0]            direction,
  input  wire logic [SYM_W-1:0]      symbol,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       result_valid,
  output logic [SYM_W-1:0]           cell_symbol,
  output logic                       is_last
);

  logic         accept;
  logic         push;
  cmd_t         push_cmd;
  logic         q_valid;
  logic         q_full;
  cmd_t         q_head;
  logic         pop;
  back_status_t bstat;

  assign busy   = rst || q_full || bstat.init_busy;
  assign accept = start && !busy;

  cfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .start_run(start_run),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .direction(direction),
    .symbol   (symbol),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .cmd      (push_cmd)
  );

  cfc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .valid   (q_valid),
    .head    (q_head),
    .full    (q_full)
  );

  cfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_head),
    .pop         (pop),
    .status      (bstat),
    .result_valid(result_valid),
    .cell_symbol (cell_symbol),
    .is_last     (is_last)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/cfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_checker: port-level checks of the frame buffer
// Reset sweep, row framing of dumped results.
// ----------------------------------------------------------------------------
module cfc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic result_valid,
  input wire logic is_last
);

  // store is being swept after reset, so no items and no results
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_quiet_after_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result right after reset");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    is_last |-> result_valid)
    else $error("is_last without result");

  // a row comes out on consecutive cycles
  a_row_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |=> result_valid)
    else $error("gap inside a dumped row");

  a_row_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_last |=> !result_valid)
    else $error("result directly after last cell");

endmodule

bind char_framebuffer_clipped_text_core cfc_checker u_cfc_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .result_valid(result_valid),
  .is_last     (is_last)
);
`default_nettype wire

FILE: tb/cfc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_frame_checker: shadow frame buffer and dump-cell checker
// Follows every accepted item and register write and keeps its own copy of
// the cells, text cursor and area registers. Each dumped cell is compared
// against the oldest cell still due.
// ----------------------------------------------------------------------------
module cfc_frame_checker import cfc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [1:0]            opcode,
  input  wire logic                  start_run,
  input  wire logic [POS_W-1:0]      pos_x,
  input  wire logic [POS_W-1:0]      pos_y,
  input  wire logic [1:0]            direction,
  input  wire logic [SYM_W-1:0]      symbol,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  result_valid,
  input  wire logic [SYM_W-1:0]      cell_symbol,
  input  wire logic                  is_last,
  output int                         fail_count,
  output int                         cells_due,
  output int                         cells_seen
);

  typedef struct packed {
    logic [SYM_W-1:0] code;
    logic             tail;
  } dumped_cell_t;

  logic [SYM_W-1:0]        screen [CELL_COUNT];
  logic [POS_W-1:0]        cur_x;
  logic [POS_W-1:0]        cur_y;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  dumped_cell_t            row_cells [$];
  int                      errs;
  int                      seen;

  function automatic int area_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(width_reg);
  endfunction

  function automatic int area_rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return int'(height_reg);
  endfunction

  // Applies one item to the shadow buffer; a dump queues the cells it shows.
  task automatic render_item(input opcode_t op, input logic run_start,
                             input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input dir_t dir, input logic [SYM_W-1:0] sym);
    int           cols;
    int           rows;
    dumped_cell_t c;
    cols = area_cols();
    rows = area_rows();
    case (op)
      OP_DRAW: begin
        if (run_start) begin
          cur_x = x;
          cur_y = y;
        end
        if (int'(cur_x) < cols && int'(cur_y) < rows)
          screen[int'(cur_y) * MAX_COLUMNS + int'(cur_x)] = sym;
        // 16-bit cursor; a wrap lands far off the area and gets clipped
        case (dir)
          DIR_UP:    cur_y = cur_y - POS_W'(1);
          DIR_DOWN:  cur_y = cur_y + POS_W'(1);
          DIR_LEFT:  cur_x = cur_x - POS_W'(1);
          default:   cur_x = cur_x + POS_W'(1);
        endcase
      end
      OP_CLEAR: begin
        foreach (screen[i]) screen[i] = SPACE_CODE;
      end
      OP_DUMP: begin
        if (int'(y) < rows) begin
          for (int col = 0; col < cols; col++) begin
            c.code = screen[int'(y) * MAX_COLUMNS + col];
            c.tail = (col == cols - 1);
            row_cells.insert(row_cells.size(), c);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input dumped_cell_t want);
    if (errs < 10)
      $display("%0t: %s: expected code %h last %b, got code %h last %b",
               $realtime, what, want.code, want.tail, cell_symbol, is_last);
    errs++;
  endtask

  always @(posedge clk) begin
    dumped_cell_t want;
    if (rst) begin
      foreach (screen[i]) screen[i] = SPACE_CODE;
      cur_x = '0;
      cur_y = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      row_cells.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (result_valid) begin
        seen++;
        if (row_cells.size() == 0) begin
          note_mismatch("cell with none pending", '0);
        end else begin
          want = row_cells.pop_front();
          if (cell_symbol !== want.code || is_last !== want.tail)
            note_mismatch($sformatf("cell mismatch at #%0d", seen), want);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data[WIDTH_REG_W-1:0];
        else if (cfg_index == REG_HEIGHT) height_reg = cfg_data[HEIGHT_REG_W-1:0];
      end
      if (start && !busy)
        render_item(opcode_t'(opcode), start_run, pos_x, pos_y, dir_t'(direction), symbol);
    end
    fail_count <= errs;
    cells_due  <= row_cells.size();
    cells_seen <= seen;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: character frame buffer with clipped text writes
// Directed corner items, then text runs, row dumps and clears with random
// content over a series of area settings, with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;
  import cfc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
  localparam int N_SETTINGS     = 8;
  localparam int ITEMS_PER_AREA = 28;
  // queue full of clears plus the one in progress
  localparam int SETTLE_CYCLES  = (QUEUE_DEPTH + 1) * CELL_COUNT + 64;
  localparam int WATCHDOG_LIMIT = 4 * SETTLE_CYCLES;
  localparam int TAIL_CYCLES    = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  opcode_t               opcode = OP_NONE;
  logic                  start_run = 1'b0;
  logic [POS_W-1:0]      pos_x = '0;
  logic [POS_W-1:0]      pos_y = '0;
  dir_t                  direction = DIR_UP;
  logic [SYM_W-1:0]      symbol = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic [SYM_W-1:0]      cell_symbol;
  logic                  is_last;

  int fail_count;
  int cells_due;
  int cells_seen;

  // raw register values; zero and over-range ones are clamped by the block
  int setting_w [N_SETTINGS] = '{64, 1, 0, 127, 17, 64, 1, 40};
  int setting_h [N_SETTINGS] = '{32, 1, 0, 63, 5, 1, 32, 20};

  int area_w = MAX_COLUMNS;
  int area_h = MAX_ROWS;
  int items_sent = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  char_framebuffer_clipped_text_core dut (
    .clk, .rst, .start, .busy, .opcode, .start_run, .pos_x, .pos_y,
    .direction, .symbol, .cfg_we, .cfg_index, .cfg_data,
    .result_valid, .cell_symbol, .is_last
  );

  cfc_frame_checker frame_check (
    .clk, .rst, .start, .busy, .opcode, .start_run, .pos_x, .pos_y,
    .direction, .symbol, .cfg_we, .cfg_index, .cfg_data,
    .result_valid, .cell_symbol, .is_last,
    .fail_count, .cells_due, .cells_seen
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Gap rate goes from 17 to 45 to none over the run.
  task automatic push_item(input opcode_t op, input logic run_start,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input dir_t dir, input logic [SYM_W-1:0] sym);
    int idle_pct;
    idle_pct = (items_sent < 80) ? 17 : (items_sent < 160) ? 45 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    start_run <= run_start;
    pos_x     <= x;
    pos_y     <= y;
    direction <= dir;
    symbol    <= sym;
    do @(posedge clk); while (busy);
    op_count[op]++;
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (cells_due != 0) @(posedge clk);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                           input bit with_spare);
    if (with_spare) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_SPARE_A;
      cfg_data  <= '1;
      @(posedge clk);
      cfg_index <= CFG_SPARE_B;
      cfg_data  <= CFG_DATA_W'(1);
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic dir_t rnd_dir();
    return dir_t'($urandom_range(3));
  endfunction

  initial begin
    int          pick;
    int          run_len;
    int          goal;
    dir_t        run_dir;
    logic [15:0] x0;
    logic [15:0] y0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset content, corners, cursor wrap, clipping, odd opcodes
    push_item(OP_DUMP, 1'b1, rnd16(), 16'd0, rnd_dir(), rnd16());
    push_item(OP_DRAW, 1'b1, 16'd0, 16'd0, DIR_RIGHT, 16'hFFFF);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_RIGHT, 16'h0000);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_DOWN, 16'h1234);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_LEFT, 16'h5A5A);
    push_item(OP_DRAW, 1'b1, 16'd63, 16'd31, DIR_DOWN, 16'hA5A5);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_LEFT, 16'hBEEF);   // below the area
    push_item(OP_DRAW, 1'b1, 16'd64, 16'd0, DIR_UP, 16'h4141);        // x at the width
    push_item(OP_DRAW, 1'b1, 16'd0, 16'd0, DIR_UP, 16'h4242);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_LEFT, 16'h4343);   // y wrapped
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_DOWN, 16'h4444);
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_RIGHT, 16'h4545);  // x wrapped
    push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), DIR_RIGHT, 16'h4646);  // back at 0,0
    push_item(OP_DRAW, 1'b1, 16'hFFFF, 16'hFFFF, DIR_RIGHT, 16'h4747);
    push_item(OP_NONE, 1'b1, rnd16(), 16'd0, rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b0, rnd16(), 16'd0, rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b1, rnd16(), 16'd1, rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b0, rnd16(), 16'd31, rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b1, rnd16(), 16'd32, rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b0, rnd16(), 16'hFFFF, rnd_dir(), rnd16());
    push_item(OP_CLEAR, 1'b1, rnd16(), rnd16(), rnd_dir(), rnd16());
    push_item(OP_DUMP, 1'b0, rnd16(), 16'd0, rnd_dir(), rnd16());

    for (int p = 0; p < N_SETTINGS; p++) begin
      // registers change only with the block quiet, clears included
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      load_regs(CFG_DATA_W'(setting_w[p]), CFG_DATA_W'(setting_h[p]), p == 0);
      area_w = (setting_w[p] == 0) ? 1 :
               (setting_w[p] > MAX_COLUMNS) ? MAX_COLUMNS : setting_w[p];
      area_h = (setting_h[p] == 0) ? 1 :
               (setting_h[p] > MAX_ROWS) ? MAX_ROWS : setting_h[p];

      goal = items_sent + ITEMS_PER_AREA;
      while (items_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // text run near the area, sometimes read back at once
          run_len = $urandom_range(8, 1);
          run_dir = rnd_dir();
          if ($urandom_range(9) == 0) begin
            x0 = rnd16();
            y0 = rnd16();
          end else begin
            x0 = 16'($urandom_range(area_w + 1));
            y0 = 16'($urandom_range(area_h + 1));
          end
          push_item(OP_DRAW, 1'b1, x0, y0, run_dir, rnd16());
          for (int k = 1; k < run_len; k++) begin
            if ($urandom_range(9) == 0) run_dir = rnd_dir();
            push_item(OP_DRAW, 1'b0, rnd16(), rnd16(), run_dir, rnd16());
          end
          if ($urandom_range(1) == 1)
            push_item(OP_DUMP, 1'($urandom_range(1)), rnd16(), y0, rnd_dir(), rnd16());
        end else if (pick < 75) begin
          push_item(OP_DUMP, 1'($urandom_range(1)), rnd16(),
                    16'($urandom_range(area_h - 1)), rnd_dir(), rnd16());
        end else if (pick < 85) begin
          push_item(OP_DRAW, 1'($urandom_range(1)), rnd16(), rnd16(), rnd_dir(), rnd16());
        end else if (pick < 90) begin
          push_item(OP_NONE, 1'($urandom_range(1)), rnd16(), rnd16(), rnd_dir(), rnd16());
        end else if (pick < 92) begin
          push_item(OP_CLEAR, 1'($urandom_range(1)), rnd16(), rnd16(), rnd_dir(), rnd16());
        end else if (pick < 95) begin
          drain();
        end else begin
          // row just past the area, or anywhere in the 16-bit range
          y0 = ($urandom_range(1) == 1) ? 16'(area_h) : rnd16();
          push_item(OP_DUMP, 1'($urandom_range(1)), rnd16(), y0, rnd_dir(), rnd16());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d draws, %0d clears, %0d row dumps, %0d ignored items over %0d areas",
             op_count[OP_DRAW], op_count[OP_CLEAR], op_count[OP_DUMP], op_count[OP_NONE],
             N_SETTINGS + 1);
    $display("%0d dumped cells compared, %0d mismatches", cells_seen, fail_count);
    if (fail_count == 0 && cells_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
